// ===== rtl/adamu_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the Adam update core.
// No dependencies; used by adam_optimizer_update_core.
`timescale 1ns / 1ps
`default_nettype none

package adamu_pkg;

  localparam int unsigned DEPTH_DEF = 4096;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MOM2_W  = 48;
  localparam int unsigned POW_W   = 33;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 48;

  // One bit of quotient or root per pipeline stage.
  localparam int unsigned MH_STEPS = 64;
  localparam int unsigned VD_STEPS = 112;
  localparam int unsigned SQ_STEPS = 56;
  localparam int unsigned SD_STEPS = 41;

  localparam logic [POW_W-1:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [40:0]      STEP_CAP = 41'h100_0000_0000;

  localparam logic [CFG_W-1:0] LR_RST  = 32'd4294967;
  localparam logic [CFG_W-1:0] B1_RST  = 32'd3865470566;
  localparam logic [CFG_W-1:0] B2_RST  = 32'd4290672329;
  localparam logic [CFG_W-1:0] EPS_RST = 32'd43;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_BETA_FIRST    = 2'd1,
    CFG_BETA_SECOND   = 2'd2,
    CFG_EPSILON       = 2'd3
  } cfg_reg_e;

  // floor(a * b / 2^32) for a below 2^48 and b up to 2^32, as two narrow products.
  function automatic logic [47:0] mul_q32(input logic [47:0] a, input logic [32:0] b);
    logic [56:0] ph;
    logic [56:0] pl;
    logic [57:0] s;
    ph = 57'(a[47:24]) * 57'(b);
    pl = 57'(a[23:0]) * 57'(b);
    s  = 58'(ph) + 58'(pl[56:24]);
    return s[55:8];
  endfunction

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/adamu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module adamu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/adam_optimizer_update_core.sv =====
// Adam optimizer update core: moment stores, bias correction, root and step division.
// Depends on adamu_pkg and adamu_ram.
//
// Usage:
// Each transaction on the slave stream carries one element: its index, current weight
// and gradient, with begins_step in tuser marking the first element of a pass. The
// block updates that element's first and second moments, applies the bias corrections
// and returns the updated weight with the index echoed on the master stream.
// Configuration registers (learning rate, both betas, epsilon) are written through a
// plain write port while no element is in flight; the user is bound to that, and the
// block itself does not enforce it. Throughput is one element per clock while the
// clearing pass is over and the skid register is not full. An element's result reaches
// the master stream through the bit-per-stage dividers (112 stages for the second
// moment, 41 for the step) and the 56-stage square root, all in one lockstep pipeline.
// After reset a clearing pass zeroes both moment stores, one entry per cycle, over all
// DEPTH entries; s_axis_tready stays low until it is done.
// When the receiver stalls, the finished result waits in the output register and one
// more result drops into a skid register; only once the skid register is full does the
// whole pipeline freeze and s_axis_tready fall. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module adam_optimizer_update_core #(
  parameter int unsigned DEPTH = adamu_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: element_index[11:0], weight_in[43:12], gradient[75:44], zero[79:76]
  input  logic [adamu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: begins_step[0]
  input  logic [0:0]                          s_axis_tuser,
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: index_out[11:0], weight_out[43:12], zero[47:44]
  output logic [adamu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [adamu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [adamu_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Reciprocal of DEPTH in 2^-24 units, rounded up; exact quotient for 12-bit indexes.
  localparam int unsigned RECIP = ((1 << 24) + DEPTH - 1) / DEPTH;
  localparam int unsigned VD    = adamu_pkg::VD_STEPS;
  localparam int unsigned SQ    = adamu_pkg::SQ_STEPS;
  localparam int unsigned SD    = adamu_pkg::SD_STEPS;

  // Per-stage payload of the second-moment and first-moment dividers.
  typedef struct packed {
    logic [11:0]  idx;
    logic [31:0]  w;
    logic         mneg;
    logic [32:0]  mrem;
    logic [63:0]  macc;
    logic [32:0]  c1;
    logic [32:0]  vrem;
    logic [111:0] vacc;
    logic [32:0]  c2;
  } bst_t;

  // Per-stage payload of the square root.
  typedef struct packed {
    logic [11:0]  idx;
    logic [31:0]  w;
    logic         mneg;
    logic [63:0]  mh;
    logic [111:0] rad;
    logic [57:0]  rem;
    logic [55:0]  root;
  } cst_t;

  // Per-stage payload of the step divider.
  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] w;
    logic        mneg;
    logic        big;
    logic [56:0] d;
    logic [56:0] rem;
    logic [40:0] acc;
  } est_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] lr_q, b1_q, b2_q, eps_q;
  logic [31:0] eps_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= adamu_pkg::LR_RST;
      b1_q  <= adamu_pkg::B1_RST;
      b2_q  <= adamu_pkg::B2_RST;
      eps_q <= adamu_pkg::EPS_RST;
    end else if (cfg_we_i) begin
      case (adamu_pkg::cfg_reg_e'(cfg_index_i))
        adamu_pkg::CFG_LEARNING_RATE: lr_q  <= cfg_data_i;
        adamu_pkg::CFG_BETA_FIRST:    b1_q  <= cfg_data_i;
        adamu_pkg::CFG_BETA_SECOND:   b2_q  <= cfg_data_i;
        adamu_pkg::CFG_EPSILON:       eps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero epsilon behaves as one unit.
  assign eps_eff = (eps_q == 32'd0) ? 32'd1 : eps_q;

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline moves together unless the skid register is full.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_vld_q, out_vld_q;
  logic clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic acc_in;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en & ~clr_busy_q;
  assign acc_in        = s_axis_tvalid & s_axis_tready;

  // Clearing pass over both moment stores after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: decay powers and slot quotient
  // ---------------------------------------------------------------------------
  logic [11:0] in_idx;
  logic [31:0] in_w, in_g;
  logic        in_begin, start;
  logic [32:0] pf_q, ps_q, pf_d, ps_d;
  logic [64:0] pf_mul, ps_mul;
  logic        started_q;
  logic [36:0] idx_prod;

  assign in_idx   = s_axis_tdata[11:0];
  assign in_w     = s_axis_tdata[43:12];
  assign in_g     = s_axis_tdata[75:44];
  assign in_begin = s_axis_tuser[0];

  // A pass start, explicit or implied by no pass yet, advances beta^t.
  assign start  = in_begin | ~started_q;
  assign pf_mul = 65'(pf_q) * 65'(b1_q);
  assign ps_mul = 65'(ps_q) * 65'(b2_q);
  assign pf_d   = start ? pf_mul[64:32] : pf_q;
  assign ps_d   = start ? ps_mul[64:32] : ps_q;

  assign idx_prod = 37'(in_idx) * 37'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q      <= adamu_pkg::ONE_Q32;
      ps_q      <= adamu_pkg::ONE_Q32;
      started_q <= 1'b0;
    end else if (acc_in) begin
      pf_q      <= pf_d;
      ps_q      <= ps_d;
      started_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: captured item
  // ---------------------------------------------------------------------------
  logic        vld1_q;
  logic [11:0] idx1_q, qd1_q;
  logic [31:0] w1_q, g1_q;
  logic [32:0] pf1_q, ps1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= acc_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q <= in_idx;
      qd1_q  <= idx_prod[35:24];
      w1_q   <= in_w;
      g1_q   <= in_g;
      pf1_q  <= pf_d;
      ps1_q  <= ps_d;
    end
  end

  // Gradient terms, slot and bias corrections.
  logic [31:0] gmag1;
  logic [32:0] omb1, c1_raw, c2_raw, c1_d, c2_d;
  logic [64:0] t2_prod;
  logic [63:0] gsq_prod;
  logic [28:0] slot_prod, slot_rem;

  assign gmag1    = adamu_pkg::mag32(g1_q);
  assign omb1     = adamu_pkg::ONE_Q32 - {1'b0, b1_q};
  assign t2_prod  = 65'(gmag1) * 65'(omb1);
  assign gsq_prod = 64'(gmag1) * 64'(gmag1);
  assign c1_raw   = adamu_pkg::ONE_Q32 - pf1_q;
  assign c2_raw   = adamu_pkg::ONE_Q32 - ps1_q;
  assign c1_d     = (c1_raw == '0) ? 33'd1 : c1_raw;
  assign c2_d     = (c2_raw == '0) ? 33'd1 : c2_raw;
  assign slot_prod = 29'(qd1_q) * 29'(DEPTH);
  assign slot_rem  = 29'(idx1_q) - slot_prod;

  // ---------------------------------------------------------------------------
  // Stage 2
  // ---------------------------------------------------------------------------
  logic          vld2_q, gneg2_q;
  logic [11:0]   idx2_q;
  logic [AW-1:0] slot2_q;
  logic [31:0]   w2_q, t2_2_q;
  logic [46:0]   gsq2_q;
  logic [32:0]   c1_2_q, c2_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx2_q  <= idx1_q;
      slot2_q <= slot_rem[AW-1:0];
      w2_q    <= w1_q;
      gneg2_q <= g1_q[31];
      t2_2_q  <= t2_prod[63:32];
      gsq2_q  <= gsq_prod[62:16];
      c1_2_q  <= c1_d;
      c2_2_q  <= c2_d;
    end
  end

  logic [32:0] omb2;
  logic [47:0] tv2;

  assign omb2 = adamu_pkg::ONE_Q32 - {1'b0, b2_q};
  assign tv2  = adamu_pkg::mul_q32({1'b0, gsq2_q}, omb2);

  // ---------------------------------------------------------------------------
  // Stage 3: moment update against the store (read issued as the item enters)
  // ---------------------------------------------------------------------------
  logic          vld3_q, gneg3_q;
  logic [11:0]   idx3_q;
  logic [AW-1:0] slot3_q;
  logic [31:0]   w3_q, t2_3_q;
  // The gradient term reaches 2^46 for the most negative gradient with a zero beta.
  logic [46:0]   tv3_q;
  logic [32:0]   c1_3_q, c2_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx3_q  <= idx2_q;
      slot3_q <= slot2_q;
      w3_q    <= w2_q;
      gneg3_q <= gneg2_q;
      t2_3_q  <= t2_2_q;
      tv3_q   <= tv2[46:0];
      c1_3_q  <= c1_2_q;
      c2_3_q  <= c2_2_q;
    end
  end

  logic          vld4_q;
  logic [11:0]   idx4_q;
  logic [AW-1:0] slot4_q;
  logic [31:0]   w4_q, m4_q;
  logic [47:0]   v4_q;
  logic [32:0]   c1_4_q, c2_4_q;

  logic [31:0] m_rdata, m_old, mmag3, t1, m_new;
  logic [47:0] v_rdata, v_old, v_new;
  logic [63:0] t1_prod;
  logic        fwd;
  logic signed [33:0] st1, st2, m_sum;
  logic [48:0] v_sum;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   m_wdata;
  logic [47:0]   v_wdata;

  // The item one stage ahead was written at the same edge this item's read was issued,
  // so its values are taken from the stage register instead of the read data.
  assign fwd   = vld4_q & (slot4_q == slot3_q);
  assign m_old = fwd ? m4_q : m_rdata;
  assign v_old = fwd ? v4_q : v_rdata;

  assign mmag3   = adamu_pkg::mag32(m_old);
  assign t1_prod = 64'(mmag3) * 64'(b1_q);
  assign t1      = t1_prod[63:32];
  assign st1     = m_old[31] ? -$signed({2'b00, t1}) : $signed({2'b00, t1});
  assign st2     = gneg3_q ? -$signed({2'b00, t2_3_q}) : $signed({2'b00, t2_3_q});
  assign m_sum   = st1 + st2;

  always_comb begin
    if (m_sum > 34'sd2147483647) begin
      m_new = 32'h7FFF_FFFF;
    end else if (m_sum < -34'sd2147483648) begin
      m_new = 32'h8000_0000;
    end else begin
      m_new = m_sum[31:0];
    end
  end

  assign v_sum = {1'b0, adamu_pkg::mul_q32(v_old, {1'b0, b2_q})} + 49'(tv3_q);
  assign v_new = v_sum[48] ? {48{1'b1}} : v_sum[47:0];

  assign ram_we    = (en & vld3_q) | clr_busy_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : slot3_q;
  assign m_wdata   = clr_busy_q ? '0 : m_new;
  assign v_wdata   = clr_busy_q ? '0 : v_new;

  adamu_ram #(
    .WIDTH (adamu_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_first_mom (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (m_wdata),
    .re_i    (en),
    .raddr_i (slot2_q),
    .rdata_o (m_rdata)
  );

  adamu_ram #(
    .WIDTH (adamu_pkg::MOM2_W),
    .DEPTH (DEPTH)
  ) u_second_mom (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (v_wdata),
    .re_i    (en),
    .raddr_i (slot2_q),
    .rdata_o (v_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: updated moments
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx4_q  <= idx3_q;
      slot4_q <= slot3_q;
      w4_q    <= w3_q;
      m4_q    <= m_new;
      v4_q    <= v_new;
      c1_4_q  <= c1_3_q;
      c2_4_q  <= c2_3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: v * 2^64 / c2 over all stages, |m| * 2^32 / c1 over the first 64
  // ---------------------------------------------------------------------------
  bst_t b_in;
  bst_t b_q     [VD];
  logic b_vld_q [VD];

  always_comb begin
    b_in      = '0;
    b_in.idx  = idx4_q;
    b_in.w    = w4_q;
    b_in.mneg = m4_q[31];
    b_in.macc = {adamu_pkg::mag32(m4_q), 32'd0};
    b_in.c1   = c1_4_q;
    b_in.vacc = {v4_q, 64'd0};
    b_in.c2   = c2_4_q;
  end

  for (genvar k = 0; k < VD; k++) begin : g_vdiv
    bst_t        src, nxt;
    logic        sv;
    logic [33:0] vsh, msh;
    logic        vge, mge;

    if (k == 0) begin : g_head
      assign src = b_in;
      assign sv  = vld4_q;
    end else begin : g_body
      assign src = b_q[k-1];
      assign sv  = b_vld_q[k-1];
    end

    always_comb begin
      nxt  = src;
      vsh  = {src.vrem, src.vacc[111]};
      vge  = vsh >= {1'b0, src.c2};
      msh  = {src.mrem, src.macc[63]};
      mge  = msh >= {1'b0, src.c1};
      nxt.vrem = vge ? 33'(vsh - {1'b0, src.c2}) : vsh[32:0];
      nxt.vacc = {src.vacc[110:0], vge};
      if (k < adamu_pkg::MH_STEPS) begin
        nxt.mrem = mge ? 33'(msh - {1'b0, src.c1}) : msh[32:0];
        nxt.macc = {src.macc[62:0], mge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_vld_q[k] <= 1'b0;
      end else if (en) begin
        b_vld_q[k] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        b_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root, two radicand bits per stage
  // ---------------------------------------------------------------------------
  cst_t c_in;
  cst_t c_q     [SQ];
  logic c_vld_q [SQ];

  always_comb begin
    c_in      = '0;
    c_in.idx  = b_q[VD-1].idx;
    c_in.w    = b_q[VD-1].w;
    c_in.mneg = b_q[VD-1].mneg;
    c_in.mh   = b_q[VD-1].macc;
    c_in.rad  = b_q[VD-1].vacc;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    cst_t        src, nxt;
    logic        sv;
    logic [59:0] rsh, trial;
    logic        ge;

    if (k == 0) begin : g_head
      assign src = c_in;
      assign sv  = b_vld_q[VD-1];
    end else begin : g_body
      assign src = c_q[k-1];
      assign sv  = c_vld_q[k-1];
    end

    always_comb begin
      nxt      = src;
      rsh      = {src.rem, src.rad[111:110]};
      trial    = {2'b00, src.root, 2'b01};
      ge       = rsh >= trial;
      nxt.rem  = ge ? 58'(rsh - trial) : rsh[57:0];
      nxt.root = {src.root[54:0], ge};
      nxt.rad  = {src.rad[109:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_vld_q[k] <= 1'b0;
      end else if (en) begin
        c_vld_q[k] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Step numerator lr * mh and divisor root + eps
  // ---------------------------------------------------------------------------
  logic        d0_vld_q, d1_vld_q, d2_vld_q;
  logic [11:0] d0_idx_q, d1_idx_q;
  logic [31:0] d0_w_q, d1_w_q;
  logic        d0_mneg_q, d1_mneg_q;
  logic [56:0] d0_d_q, d1_d_q;
  logic [63:0] d0_plo_q, d0_phi_q;
  logic [95:0] d1_n_q;
  est_t        d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
    end else if (en) begin
      d0_vld_q <= c_vld_q[SQ-1];
      d1_vld_q <= d0_vld_q;
      d2_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_idx_q  <= c_q[SQ-1].idx;
      d0_w_q    <= c_q[SQ-1].w;
      d0_mneg_q <= c_q[SQ-1].mneg;
      d0_d_q    <= 57'(c_q[SQ-1].root) + 57'(eps_eff);
      d0_plo_q  <= 64'(lr_q) * 64'(c_q[SQ-1].mh[31:0]);
      d0_phi_q  <= 64'(lr_q) * 64'(c_q[SQ-1].mh[63:32]);

      d1_idx_q  <= d0_idx_q;
      d1_w_q    <= d0_w_q;
      d1_mneg_q <= d0_mneg_q;
      d1_d_q    <= d0_d_q;
      d1_n_q    <= {d0_phi_q, 32'd0} + 96'(d0_plo_q);

      // A quotient of 2^41 or more is settled here; the divider resolves the low bits.
      d2_q.idx  <= d1_idx_q;
      d2_q.w    <= d1_w_q;
      d2_q.mneg <= d1_mneg_q;
      d2_q.big  <= {2'b00, d1_n_q[95:41]} >= d1_d_q;
      d2_q.d    <= d1_d_q;
      d2_q.rem  <= {2'b00, d1_n_q[95:41]};
      d2_q.acc  <= d1_n_q[40:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Step divider, one quotient bit per stage
  // ---------------------------------------------------------------------------
  est_t e_q     [SD];
  logic e_vld_q [SD];

  for (genvar k = 0; k < SD; k++) begin : g_sdiv
    est_t        src, nxt;
    logic        sv;
    logic [57:0] sh;
    logic        ge;

    if (k == 0) begin : g_head
      assign src = d2_q;
      assign sv  = d2_vld_q;
    end else begin : g_body
      assign src = e_q[k-1];
      assign sv  = e_vld_q[k-1];
    end

    always_comb begin
      nxt     = src;
      sh      = {src.rem, src.acc[40]};
      ge      = sh >= {1'b0, src.d};
      nxt.rem = ge ? 57'(sh - {1'b0, src.d}) : sh[56:0];
      nxt.acc = {src.acc[39:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        e_vld_q[k] <= 1'b0;
      end else if (en) begin
        e_vld_q[k] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final weight: apply the capped step against the sign of the new first moment.
  // ---------------------------------------------------------------------------
  logic [40:0]        step;
  logic signed [42:0] w_ext, r_ext;
  logic [31:0]        res;
  logic               f_vld_q;
  logic [43:0]        f_data_q;

  assign step  = (e_q[SD-1].big | (e_q[SD-1].acc > adamu_pkg::STEP_CAP)) ?
                 adamu_pkg::STEP_CAP : e_q[SD-1].acc;
  assign w_ext = 43'(signed'(e_q[SD-1].w));
  assign r_ext = e_q[SD-1].mneg ? (w_ext + $signed({2'b00, step}))
                                : (w_ext - $signed({2'b00, step}));

  always_comb begin
    if (r_ext > 43'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (r_ext < -43'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = r_ext[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q[SD-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_data_q <= {res, e_q[SD-1].idx};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register
  // ---------------------------------------------------------------------------
  logic [43:0] out_data_q, skid_data_q;
  logic        take, push;

  assign take = out_vld_q & m_axis_tready;
  assign push = f_vld_q & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_data_q <= f_data_q;
      end else begin
        skid_data_q <= f_data_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input accepted during the moment store clearing pass");

  a_store_port_free_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(vld1_q || vld2_q || vld3_q || vld4_q))
    else $error("item reached the moment stores during the clearing pass");

  a_pass_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> started_q)
    else $error("accepted item did not mark a pass as started");

endmodule

`default_nettype wire

// ===== dv/adam_optimizer_update_core_tb.sv =====
// Self-checking testbench for adam_optimizer_update_core: directed rows, then random passes.
// Depends on adamu_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module adam_optimizer_update_core_tb;

  // Used for the final drain, after the last expected update has arrived.
  localparam int unsigned LATENCY = 217;
  localparam logic [63:0] ONE_Q = 64'd1 << 32;
  localparam logic [63:0] CAP_Q = 64'd1 << 40;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [adamu_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [adamu_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  logic [adamu_pkg::CFG_IDX_W-1:0] cfg_index_i = adamu_pkg::CFG_LEARNING_RATE;
  logic [adamu_pkg::CFG_W-1:0]     cfg_data_i = '0;

  adam_optimizer_update_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // One row of the directed table. When known is set, the updated weight can be
  // read off at a glance (zero gradient on a fresh element leaves the weight alone)
  // and the typed value is what the block must return.
  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] w;
    logic [31:0] g;
    logic        beg;
    logic        known;
    logic [31:0] w_exp;
  } row_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] w;
  } update_t;

  typedef struct packed {
    logic        known;
    logic [31:0] w_exp;
  } hint_t;

  typedef struct packed {
    logic [31:0] lr;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] eps;
  } setting_t;

  localparam int unsigned N_ROWS = 16;
  row_t dir_rows [N_ROWS] = '{
    // Before any pass has begun: begins_step low still opens a pass.
    '{12'd0,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{12'd4095, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{12'd7,    32'h0123_4567, 32'h0000_0000, 1'b0, 1'b1, 32'h0123_4567},
    // Gradient extremes on one element so both moments build up.
    '{12'd1,    32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{12'd1,    32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{12'd1,    32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
    // Weight pushed past the top and bottom of the range, so it saturates.
    '{12'd2,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{12'd3,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{12'd2,    32'h7FFF_FF00, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{12'd3,    32'h8000_0100, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    // Tiny gradients of either sign, then a sign flip on the same element.
    '{12'd4,    32'h0100_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{12'd4,    32'h0100_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{12'd4095, 32'hFFFF_FFFF, 32'h0100_0000, 1'b1, 1'b0, 32'h0},
    '{12'd4095, 32'h0000_0001, 32'hFF00_0000, 1'b0, 1'b0, 32'h0},
    '{12'd2048, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{12'd2730, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0}
  };

  localparam int unsigned N_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 322;

  // Optimizer state mirrored by the predictor.
  logic [31:0]        lr_q = adamu_pkg::LR_RST;
  logic [31:0]        b1_q = adamu_pkg::B1_RST;
  logic [31:0]        b2_q = adamu_pkg::B2_RST;
  logic [31:0]        eps_q = adamu_pkg::EPS_RST;
  logic signed [31:0] m_mem [adamu_pkg::DEPTH_DEF];
  logic [47:0]        v_mem [adamu_pkg::DEPTH_DEF];
  logic [32:0]        pow1_q = adamu_pkg::ONE_Q32;
  logic [32:0]        pow2_q = adamu_pkg::ONE_Q32;
  bit                 pass_open = 1'b0;

  update_t weight_queue [$];
  hint_t   hint_queue [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  bit          calm = 1'b0;
  bit          held = 1'b0;

  initial begin
    for (int i = 0; i < adamu_pkg::DEPTH_DEF; i++) begin
      m_mem[i] = '0;
      v_mem[i] = '0;
    end
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // floor(a * b / 2^32) without overflow.
  function automatic logic [63:0] scale_q32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 32);
  endfunction

  // Applies one element to the mirrored state and returns the updated weight.
  function automatic logic [31:0] adam_weight(input logic [11:0] idx,
                                              input logic signed [31:0] w,
                                              input logic signed [31:0] g,
                                              input logic beg);
    logic [11:0]        slot;
    logic signed [63:0] ms, gs, mnew, res;
    logic [63:0]        mmag, gmag, t1, t2, gsq, vnew, c1, c2, mh, d, root, cand, step;
    logic [127:0]       rad, quo;
    slot = 12'(idx % adamu_pkg::DEPTH_DEF);
    if (beg || !pass_open) begin
      pow1_q = 33'((65'(pow1_q) * 65'(b1_q)) >> 32);
      pow2_q = 33'((65'(pow2_q) * 65'(b2_q)) >> 32);
      pass_open = 1'b1;
    end

    ms = m_mem[slot];
    gs = g;
    mmag = (ms < 0) ? 64'(-ms) : 64'(ms);
    gmag = (gs < 0) ? 64'(-gs) : 64'(gs);
    t1 = scale_q32(mmag, 64'(b1_q));
    t2 = scale_q32(gmag, ONE_Q - 64'(b1_q));
    mnew = ((ms < 0) ? -$signed(t1) : $signed(t1)) + ((gs < 0) ? -$signed(t2) : $signed(t2));
    if (mnew > 64'sd2147483647) mnew = 64'sd2147483647;
    if (mnew < -64'sd2147483648) mnew = -64'sd2147483648;
    m_mem[slot] = 32'(mnew);

    gsq = (gmag * gmag) >> 16;
    vnew = scale_q32(64'(v_mem[slot]), 64'(b2_q)) + scale_q32(gsq, ONE_Q - 64'(b2_q));
    if (vnew > 64'hFFFF_FFFF_FFFF) vnew = 64'hFFFF_FFFF_FFFF;
    v_mem[slot] = 48'(vnew);

    c1 = ONE_Q - 64'(pow1_q);
    c2 = ONE_Q - 64'(pow2_q);
    if (c1 == 0) c1 = 1;
    if (c2 == 0) c2 = 1;

    mmag = (mnew < 0) ? 64'(-mnew) : 64'(mnew);
    mh = (mmag << 32) / c1;
    rad = (128'(vnew) << 64) / 128'(c2);
    root = '0;
    for (int b = 56; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= rad) root = cand;
    end
    d = root + ((eps_q == 0) ? 64'd1 : 64'(eps_q));
    quo = (128'(lr_q) * 128'(mh)) / 128'(d);
    step = (quo > 128'(CAP_Q)) ? CAP_Q : 64'(quo);

    res = (mnew < 0) ? 64'(w) + $signed(step) : 64'(w) - $signed(step);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return 32'(res);
  endfunction

  // Watches both streams and the write port at each edge. Register writes update the
  // mirrored settings, accepted elements go through the predictor, and every result
  // transaction is checked against the oldest expected update.
  always @(posedge clk_i) begin
    update_t exp_u;
    hint_t   h;
    if (cfg_we_i) begin
      case (adamu_pkg::cfg_reg_e'(cfg_index_i))
        adamu_pkg::CFG_LEARNING_RATE: lr_q <= cfg_data_i;
        adamu_pkg::CFG_BETA_FIRST:    b1_q <= cfg_data_i;
        adamu_pkg::CFG_BETA_SECOND:   b2_q <= cfg_data_i;
        adamu_pkg::CFG_EPSILON:       eps_q <= cfg_data_i;
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      exp_u.idx = s_axis_tdata[11:0];
      exp_u.w = adam_weight(s_axis_tdata[11:0], s_axis_tdata[43:12], s_axis_tdata[75:44],
                            s_axis_tuser[0]);
      h = hint_queue.pop_front();
      if (h.known) exp_u.w = h.w_exp;
      weight_queue.push_back(exp_u);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      received <= received + 1;
      if (weight_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual idx %0d weight %h",
                 $time, m_axis_tdata[11:0], m_axis_tdata[43:12]);
      end else begin
        exp_u = weight_queue.pop_front();
        if (m_axis_tdata[11:0] !== exp_u.idx) begin
          errors++;
          $display("%0t: index_out mismatch: expected %0d, actual %0d",
                   $time, exp_u.idx, m_axis_tdata[11:0]);
        end
        if (m_axis_tdata[43:12] !== exp_u.w) begin
          errors++;
          $display("%0t: weight_out mismatch (idx %0d): expected %h, actual %h",
                   $time, exp_u.idx, exp_u.w, m_axis_tdata[43:12]);
        end
      end
    end
  end

  // Receiver: random back-pressure, a calm stretch with none, and one long hold-off
  // that lets the pipeline and skid register fill so the input stream stalls.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && received >= 700) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // Offers one element and holds it until the core takes it. Valid is only dropped
  // during a random gap, never between back-to-back transactions.
  task automatic send_element(input logic [11:0] idx, input logic [31:0] w,
                              input logic [31:0] g, input logic beg,
                              input logic known, input logic [31:0] w_exp);
    hint_t h;
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    h.known = known;
    h.w_exp = w_exp;
    hint_queue.push_back(h);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, g, w, idx};
    s_axis_tuser <= beg;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    calm = (sent >= 1000 && sent < 1300);
  endtask

  // Registers may only change with nothing in flight.
  task automatic write_settings(input setting_t s);
    s_axis_tvalid <= 1'b0;
    while (weight_queue.size() != 0 || hint_queue.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= adamu_pkg::CFG_LEARNING_RATE;
    cfg_data_i <= s.lr;
    @(posedge clk_i);
    cfg_index_i <= adamu_pkg::CFG_BETA_FIRST;
    cfg_data_i <= s.b1;
    @(posedge clk_i);
    cfg_index_i <= adamu_pkg::CFG_BETA_SECOND;
    cfg_data_i <= s.b2;
    @(posedge clk_i);
    cfg_index_i <= adamu_pkg::CFG_EPSILON;
    cfg_data_i <= s.eps;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    setting_t    phase_cfg [N_PHASES];
    logic [11:0] idx;
    logic [31:0] w, g;
    logic        beg;
    int unsigned drain;

    // Extremes first: full step with no decay and epsilon zero (read as one), then
    // zero step with maximal decay, the reset values, then mid, random and mid settings.
    phase_cfg[0] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    phase_cfg[1] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    phase_cfg[2] = '{adamu_pkg::LR_RST, adamu_pkg::B1_RST, adamu_pkg::B2_RST,
                     adamu_pkg::EPS_RST};
    phase_cfg[3] = '{32'h1000_0000, 32'h8000_0000, 32'hF000_0000, 32'h0000_0001};
    phase_cfg[4] = '{$urandom, $urandom, $urandom, $urandom};
    phase_cfg[5] = '{32'h0100_0000, 32'hE666_6666, 32'hFFBE_76C9, 32'd1000};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_element(dir_rows[i].idx, dir_rows[i].w, dir_rows[i].g, dir_rows[i].beg,
                   dir_rows[i].known, dir_rows[i].w_exp);

    for (int p = 0; p < N_PHASES; p++) begin
      write_settings(phase_cfg[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Most traffic revisits a small set of elements so the moments accumulate
        // over many passes; the rest spreads over the whole store.
        idx = ($urandom_range(0, 99) < 70) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        case ($urandom_range(0, 7))
          0, 1: g = $urandom;
          2: g = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          3: g = 32'($signed($urandom_range(0, 32'h0100_0000)) *
                     (($urandom_range(0, 1) != 0) ? 1 : -1));
          4: g = '0;
          default: g = 32'($signed(20'($urandom)));
        endcase
        case ($urandom_range(0, 5))
          0: w = 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
          1: w = 32'h8000_0000 + 32'($urandom_range(0, 255));
          default: w = $urandom;
        endcase
        beg = ($urandom_range(0, 39) == 0);
        send_element(idx, w, g, beg, 1'b0, 32'h0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every expected update, then a latency's worth more to catch strays.
    drain = 0;
    while ((weight_queue.size() != 0 || hint_queue.size() != 0) && drain < 100_000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 20) @(posedge clk_i);
    if (weight_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d updates still expected, none arrived", $time, weight_queue.size());
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
